FILE: rtl/ddq_pkg.sv
// ddq_pkg: request/result types and code constants for the dedup dispatch queue.
// Used by ddq_queue and dedup_dispatch_queue_watchdog_unit; no dependencies.
package ddq_pkg;

    localparam int IdFieldW = 16;

    localparam logic [1:0] MODE_SUBMIT = 2'd0;
    localparam logic [1:0] MODE_REPORT = 2'd1;
    localparam logic [1:0] MODE_STOP   = 2'd2;
    localparam logic [1:0] MODE_TICK   = 2'd3;

    localparam logic [2:0] ST_READY  = 3'd0;
    localparam logic [2:0] ST_BUSY   = 3'd1;
    localparam logic [2:0] ST_ERROR  = 3'd2;
    localparam logic [2:0] ST_UNAVAIL = 3'd3;
    localparam logic [2:0] ST_OTHER  = 3'd4;

    localparam logic [1:0] SUB_NONE     = 2'd0;
    localparam logic [1:0] SUB_REJECTED = 2'd1;
    localparam logic [1:0] SUB_COALESCE = 2'd2;
    localparam logic [1:0] SUB_ACCEPTED = 2'd3;

    localparam logic [15:0] TIMEOUT_RST = 16'd1000;

    typedef struct packed {
        logic [1:0]          mode;
        logic [IdFieldW-1:0] item_id;
        logic [2:0]          reported_state;
    } t_ddq_req;

    typedef struct packed {
        logic [1:0]          submit_result;
        logic                start_valid;
        logic [IdFieldW-1:0] start_id;
        logic                stop_request;
        logic [2:0]          backend_now;
        logic                available;
        logic                idle;
        logic [3:0]          queued_count;
        logic                awaiting_stop_ack;
    } t_ddq_res;

    typedef struct packed {
        logic clr;
        logic app;
        logic pop;
    } t_q_ctl;

endpackage

FILE: rtl/ddq_queue.sv
// ddq_queue: shifting pending-id FIFO, head always at entry 0, drop-oldest on full.
// Parallel match against valid entries. Depends on ddq_pkg.
module ddq_queue
    import ddq_pkg::*;
#(
    parameter int MaxPending = 8,
    parameter int IdW        = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  t_q_ctl                            i_ctl,
    input  logic [IdW-1:0]                    i_id,
    output logic                              o_hit,
    output logic [$clog2(MaxPending+1)-1:0]   o_fill,
    output logic [$clog2(MaxPending+1)-1:0]   o_fill_nxt,
    output logic [IdW-1:0]                    o_head
);

    localparam int FillW = $clog2(MaxPending + 1);

    logic [IdW-1:0]   r_q [MaxPending];
    logic [IdW-1:0]   n_q [MaxPending];
    logic [IdW-1:0]   ext [MaxPending+2];
    logic [FillW-1:0] r_fill;
    logic [FillW-1:0] n_fill;
    logic             drop;
    logic [1:0]       shift;

    always_comb begin
        for (int i = 0; i < MaxPending; i++) begin
            ext[i] = (i_ctl.app && r_fill == FillW'(i)) ? i_id : r_q[i];
        end
        ext[MaxPending]   = i_id;
        ext[MaxPending+1] = i_id;
        drop  = i_ctl.app && (r_fill == FillW'(MaxPending));
        shift = {1'b0, drop} + {1'b0, i_ctl.pop};
        o_head = drop ? ext[1] : ext[0];
        for (int i = 0; i < MaxPending; i++) begin
            case (shift)
                2'd0: n_q[i] = ext[i];
                2'd1: n_q[i] = ext[i+1];
                default: n_q[i] = ext[i+2];
            endcase
        end
        if (i_ctl.clr) begin
            n_fill = '0;
        end else begin
            n_fill = r_fill + FillW'(i_ctl.app) - FillW'(drop) - FillW'(i_ctl.pop);
        end
    end

    always_comb begin
        o_hit = 1'b0;
        for (int i = 0; i < MaxPending; i++) begin
            if (FillW'(i) < r_fill && r_q[i] == i_id) begin
                o_hit = 1'b1;
            end
        end
    end

    assign o_fill     = r_fill;
    assign o_fill_nxt = n_fill;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
        end else begin
            r_fill <= n_fill;
        end
    end

    always_ff @(posedge i_clk) begin
        r_q <= n_q;
    end

endmodule

FILE: rtl/dedup_dispatch_queue_watchdog_unit.sv
// dedup_dispatch_queue_watchdog_unit: top level, request register, dispatch/watchdog control.
// The request is registered into r_in, then the result into r_out; one request per cycle, busy stays low.
// Receiver cannot stall; each result is shown for one cycle only.
// Sync active-low reset: no job, empty queue, backend unavailable, timeout 1000.
// Depends on ddq_pkg and ddq_queue.
module dedup_dispatch_queue_watchdog_unit
    import ddq_pkg::*;
#(
    parameter int MAX_PENDING = 8,
    parameter int ID_BITS     = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  t_ddq_req    i_req,
    output logic        o_res_vld,
    output t_ddq_res    o_res,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [15:0] i_cfg_data
);

    localparam int IdW   = (ID_BITS < IdFieldW) ? ID_BITS : IdFieldW;
    localparam int FillW = $clog2(MAX_PENDING + 1);

    logic             r_in_vld;
    t_ddq_req         r_in;
    logic             r_out_vld;
    t_ddq_res         r_out;
    logic [15:0]      r_timeout;

    logic [IdW-1:0]   r_cur,   n_cur;
    logic [2:0]       r_trk,   n_trk;
    logic             r_swait, n_swait;
    logic [15:0]      r_left,  n_left;
    logic             r_armed, n_armed;

    t_q_ctl           q_ctl;
    logic             q_hit;
    logic [FillW-1:0] q_fill;
    logic [FillW-1:0] q_fill_nxt;
    logic [IdW-1:0]   q_head;

    logic [IdW-1:0]   id;
    logic [2:0]       rs;
    logic             avail;
    logic             try_go;
    logic             started;
    logic             stopreq;
    logic [1:0]       sres;
    logic [15:0]      arm_val;
    logic [15:0]      left_dec;
    t_ddq_res         n_out;

    assign busy        = 1'b0;
    assign o_cfg_ready = 1'b1;
    assign o_res_vld   = r_out_vld;
    assign o_res       = r_out;

    assign id      = r_in.item_id[IdW-1:0];
    assign rs      = (r_in.reported_state > ST_OTHER) ? ST_OTHER : r_in.reported_state;
    assign avail   = (r_trk == ST_READY) || (r_trk == ST_BUSY);
    assign arm_val = (r_timeout == 16'd0) ? 16'd1 : r_timeout;

    ddq_queue #(
        .MaxPending (MAX_PENDING),
        .IdW        (IdW)
    ) u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (q_ctl),
        .i_id       (id),
        .o_hit      (q_hit),
        .o_fill     (q_fill),
        .o_fill_nxt (q_fill_nxt),
        .o_head     (q_head)
    );

    always_comb begin
        n_cur    = r_cur;
        n_trk    = r_trk;
        n_swait  = r_swait;
        n_left   = r_left;
        n_armed  = r_armed;
        q_ctl    = '0;
        try_go   = 1'b0;
        started  = 1'b0;
        stopreq  = 1'b0;
        sres     = SUB_NONE;
        left_dec = r_left - 16'(r_left != 16'd0);
        if (r_in_vld) begin
            case (r_in.mode)
                MODE_SUBMIT: begin
                    if (id == '0 || !avail) begin
                        sres = SUB_REJECTED;
                    end else if (id == r_cur || q_hit) begin
                        sres = SUB_COALESCE;
                    end else begin
                        sres      = SUB_ACCEPTED;
                        q_ctl.app = 1'b1;
                        try_go    = 1'b1;
                    end
                end
                MODE_REPORT: begin
                    n_trk = rs;
                    if (rs == ST_ERROR || rs == ST_UNAVAIL) begin
                        q_ctl.clr = 1'b1;
                        n_cur     = '0;
                        n_swait   = 1'b0;
                        n_left    = 16'd0;
                        n_armed   = 1'b0;
                    end else if (rs == ST_READY) begin
                        if (r_swait) begin
                            n_swait = 1'b0;
                            n_armed = 1'b0;
                        end else if (r_cur != '0) begin
                            n_cur   = '0;
                            n_armed = 1'b0;
                        end
                        try_go = 1'b1;
                    end
                end
                MODE_STOP: begin
                    q_ctl.clr = 1'b1;
                    n_cur     = '0;
                    n_swait   = 1'b0;
                    n_left    = 16'd0;
                    n_armed   = 1'b0;
                    stopreq   = 1'b1;
                end
                default: begin
                    if (r_armed) begin
                        n_left = left_dec;
                        if (left_dec == 16'd0) begin
                            n_armed = 1'b0;
                            if (r_swait) begin
                                q_ctl.clr = 1'b1;
                                n_cur     = '0;
                                n_swait   = 1'b0;
                                n_left    = 16'd0;
                                n_trk     = ST_UNAVAIL;
                            end else if (r_cur != '0) begin
                                n_cur   = '0;
                                n_swait = 1'b1;
                                stopreq = 1'b1;
                                n_left  = arm_val;
                                n_armed = 1'b1;
                            end
                        end
                    end
                end
            endcase
            // start the head job when the backend is free
            if (try_go && n_trk == ST_READY && n_cur == '0 &&
                (q_ctl.app || q_fill != '0)) begin
                q_ctl.pop = 1'b1;
                started   = 1'b1;
                n_cur     = q_head;
                n_trk     = ST_BUSY;
                n_left    = arm_val;
                n_armed   = 1'b1;
            end
        end
    end

    always_comb begin
        n_out.submit_result     = sres;
        n_out.start_valid       = started;
        n_out.start_id          = started ? IdFieldW'(q_head) : '0;
        n_out.stop_request      = stopreq;
        n_out.backend_now       = n_trk;
        n_out.available         = (n_trk == ST_READY) || (n_trk == ST_BUSY);
        n_out.idle              = (n_trk == ST_READY) && (n_cur == '0) && (q_fill_nxt == '0);
        n_out.queued_count      = 4'(q_fill_nxt);
        n_out.awaiting_stop_ack = n_swait;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
            r_timeout <= TIMEOUT_RST;
            r_cur     <= '0;
            r_trk     <= ST_UNAVAIL;
            r_swait   <= 1'b0;
            r_left    <= 16'd0;
            r_armed   <= 1'b0;
        end else begin
            r_in_vld  <= start && !busy;
            r_out_vld <= r_in_vld;
            if (i_cfg_valid && o_cfg_ready) begin
                r_timeout <= i_cfg_data;
            end
            r_cur   <= n_cur;
            r_trk   <= n_trk;
            r_swait <= n_swait;
            r_left  <= n_left;
            r_armed <= n_armed;
        end
    end

    always_ff @(posedge i_clk) begin
        if (start && !busy) begin
            r_in <= i_req;
        end
        if (r_in_vld) begin
            r_out <= n_out;
        end
    end

`ifndef ASSERT_OFF
    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_vld && o_res.start_valid |-> o_res.backend_now == ST_BUSY)
        else $error("start reported without busy backend");

    a_start_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_vld && o_res.start_valid |-> o_res.start_id != '0)
        else $error("empty job started");

    a_stop_not_submit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_vld && o_res.stop_request |-> o_res.submit_result == SUB_NONE)
        else $error("stop request on a submit");

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_fill <= FillW'(MAX_PENDING))
        else $error("queue overfilled");

    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |-> ##2 o_res_vld)
        else $error("result strobe missing");
`endif

endmodule

FILE: tb/testbench.sv
// testbench: checks dedup_dispatch_queue_watchdog_unit with a directed table and then random
// request bursts at several watchdog intervals; each result is checked against its table row or
// an in-bench predictor. Depends on ddq_pkg and the top level of the block.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import ddq_pkg::*;

    localparam int QDEPTH = 8;
    localparam int PHASE_REQS = 115;
    localparam int MAX_ERR_PRINT = 30;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    t_ddq_req    i_req = '0;
    logic        o_res_vld;
    t_ddq_res    o_res;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [15:0] i_cfg_data = '0;

    dedup_dispatch_queue_watchdog_unit u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_req       (i_req),
        .o_res_vld   (o_res_vld),
        .o_res       (o_res),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    always #4 i_clk = ~i_clk;

    // dispatcher state as the predictor tracks it
    logic [15:0] pend_ids [QDEPTH];
    int          q_head = 0;
    int          q_fill = 0;
    logic [15:0] cur_job = '0;
    logic [15:0] wd_left = '0;
    logic [15:0] tmo = TIMEOUT_RST;
    logic [2:0]  bk_state = ST_UNAVAIL;
    bit          stop_wait = 1'b0;
    bit          wd_armed = 1'b0;

    t_ddq_res    pending_res [$];

    int n_reqs = 0;
    int n_results = 0;
    int n_starts = 0;
    int n_stops = 0;
    int n_coalesced = 0;
    int n_rejected = 0;
    int n_full = 0;
    int n_err = 0;

    typedef struct {
        bit          cfg_write;
        logic [15:0] cfg_val;
        t_ddq_req    req;
        bit          typed;
        t_ddq_res    res;
    } t_dir_row;

    t_dir_row dir_rows [$];

    function automatic bit bk_avail();
        return bk_state == ST_READY || bk_state == ST_BUSY;
    endfunction

    function automatic void arm_watchdog();
        wd_left  = (tmo == 16'd0) ? 16'd1 : tmo;
        wd_armed = 1'b1;
    endfunction

    function automatic void clear_dispatch();
        wd_armed  = 1'b0;
        wd_left   = '0;
        cur_job   = '0;
        q_head    = 0;
        q_fill    = 0;
        stop_wait = 1'b0;
    endfunction

    function automatic void start_head(inout t_ddq_res o);
        if (bk_state != ST_READY || cur_job != 16'd0 || q_fill == 0)
            return;
        cur_job  = pend_ids[q_head];
        q_head   = (q_head + 1) % QDEPTH;
        q_fill   = q_fill - 1;
        bk_state = ST_BUSY;
        arm_watchdog();
        o.start_valid = 1'b1;
        o.start_id    = cur_job;
    endfunction

    function automatic t_ddq_res predict_dispatch(input t_ddq_req r);
        t_ddq_res   o;
        logic [2:0] rs;
        bit         dup;
        o   = '0;
        dup = 1'b0;
        rs  = (r.reported_state > ST_OTHER) ? ST_OTHER : r.reported_state;
        case (r.mode)
            MODE_SUBMIT: begin
                if (r.item_id == 16'd0 || !bk_avail()) begin
                    o.submit_result = SUB_REJECTED;
                end else begin
                    for (int k = 0; k < q_fill; k++)
                        if (pend_ids[(q_head + k) % QDEPTH] == r.item_id)
                            dup = 1'b1;
                    if (r.item_id == cur_job || dup) begin
                        o.submit_result = SUB_COALESCE;
                    end else begin
                        if (q_fill >= QDEPTH) begin
                            q_head = (q_head + 1) % QDEPTH;
                            q_fill = QDEPTH - 1;
                        end
                        pend_ids[(q_head + q_fill) % QDEPTH] = r.item_id;
                        q_fill = q_fill + 1;
                        start_head(o);
                        o.submit_result = SUB_ACCEPTED;
                    end
                end
            end
            MODE_REPORT: begin
                bk_state = rs;
                if (rs == ST_ERROR || rs == ST_UNAVAIL) begin
                    clear_dispatch();
                end else if (rs == ST_READY) begin
                    if (stop_wait) begin
                        stop_wait = 1'b0;
                        wd_armed  = 1'b0;
                    end else if (cur_job != 16'd0) begin
                        cur_job  = '0;
                        wd_armed = 1'b0;
                    end
                    start_head(o);
                end
            end
            MODE_STOP: begin
                clear_dispatch();
                o.stop_request = 1'b1;
            end
            default: begin
                if (wd_armed) begin
                    if (wd_left > 16'd0)
                        wd_left = wd_left - 16'd1;
                    if (wd_left == 16'd0) begin
                        wd_armed = 1'b0;
                        if (stop_wait) begin
                            clear_dispatch();
                            bk_state = ST_UNAVAIL;
                        end else if (cur_job != 16'd0) begin
                            cur_job        = '0;
                            stop_wait      = 1'b1;
                            o.stop_request = 1'b1;
                            arm_watchdog();
                        end
                    end
                end
            end
        endcase
        o.backend_now       = bk_state;
        o.available         = bk_avail();
        o.idle              = (bk_state == ST_READY && cur_job == 16'd0 && q_fill == 0);
        o.queued_count      = 4'(q_fill);
        o.awaiting_stop_ack = stop_wait;
        return o;
    endfunction

    function automatic t_ddq_res res_of(input logic [1:0] sub, input logic sv,
                                        input logic [15:0] sid, input logic stp,
                                        input logic [2:0] bk, input logic av, input logic idl,
                                        input logic [3:0] qc, input logic aw);
        t_ddq_res o;
        o.submit_result     = sub;
        o.start_valid       = sv;
        o.start_id          = sid;
        o.stop_request      = stp;
        o.backend_now       = bk;
        o.available         = av;
        o.idle              = idl;
        o.queued_count      = qc;
        o.awaiting_stop_ack = aw;
        return o;
    endfunction

    function automatic void add_row(input logic [1:0] m, input logic [15:0] id,
                                    input logic [2:0] rs, input bit typed, input t_ddq_res r);
        t_dir_row row;
        row.cfg_write = 1'b0;
        row.cfg_val   = '0;
        row.req       = '{mode: m, item_id: id, reported_state: rs};
        row.typed     = typed;
        row.res       = r;
        dir_rows.push_back(row);
    endfunction

    function automatic void add_cfg_row(input logic [15:0] v);
        t_dir_row row;
        row           = '{default: '0};
        row.cfg_write = 1'b1;
        row.cfg_val   = v;
        dir_rows.push_back(row);
    endfunction

    function automatic t_ddq_req rand_dispatch_req();
        t_ddq_req r;
        int       sel;
        sel = $urandom_range(0, 99);
        if (sel < 42)
            r.mode = MODE_SUBMIT;
        else if (sel < 62)
            r.mode = MODE_REPORT;
        else if (sel < 66)
            r.mode = MODE_STOP;
        else
            r.mode = MODE_TICK;
        sel = $urandom_range(0, 9);
        if (sel <= 5)
            r.item_id = 16'($urandom_range(1, 12));
        else if (sel == 6)
            r.item_id = '0;
        else if (sel == 7)
            r.item_id = 16'hFFFF;
        else
            r.item_id = 16'($urandom);
        sel = $urandom_range(0, 19);
        if (sel <= 8)
            r.reported_state = ST_READY;
        else if (sel <= 11)
            r.reported_state = ST_BUSY;
        else if (sel == 12)
            r.reported_state = ST_ERROR;
        else if (sel == 13)
            r.reported_state = ST_UNAVAIL;
        else if (sel <= 15)
            r.reported_state = ST_OTHER;
        else
            r.reported_state = 3'($urandom_range(5, 7));
        return r;
    endfunction

    task automatic issue_req(input t_ddq_req r, input bit typed, input t_ddq_res typed_res);
        t_ddq_res want;
        start <= 1'b1;
        i_req <= r;
        @(posedge i_clk);
        while (busy)
            @(posedge i_clk);
        want = predict_dispatch(r);
        pending_res.push_back(typed ? typed_res : want);
        n_reqs++;
    endtask

    task automatic drain_results();
        start <= 1'b0;
        do
            @(posedge i_clk);
        while (pending_res.size() != 0);
    endtask

    task automatic write_timeout(input logic [15:0] v);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= v;
        @(posedge i_clk);
        while (!o_cfg_ready)
            @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        tmo = v;
    endtask

    task automatic cmp_field(input string name, input logic [15:0] want, input logic [15:0] got);
        if (want !== got) begin
            n_err++;
            if (n_err <= MAX_ERR_PRINT)
                $display("%0d ns: %s mismatch, expected %h, got %h", $time, name, want, got);
        end
    endtask

    always @(posedge i_clk) begin
        t_ddq_res want;
        if (i_rst_n && o_res_vld) begin
            n_results++;
            if (pending_res.size() == 0) begin
                n_err++;
                if (n_err <= MAX_ERR_PRINT)
                    $display("%0d ns: unexpected result, expected none, got %h", $time, o_res);
            end else begin
                want = pending_res.pop_front();
                cmp_field("submit_result", 16'(want.submit_result), 16'(o_res.submit_result));
                cmp_field("start_valid", 16'(want.start_valid), 16'(o_res.start_valid));
                cmp_field("start_id", want.start_id, o_res.start_id);
                cmp_field("stop_request", 16'(want.stop_request), 16'(o_res.stop_request));
                cmp_field("backend_now", 16'(want.backend_now), 16'(o_res.backend_now));
                cmp_field("available", 16'(want.available), 16'(o_res.available));
                cmp_field("idle", 16'(want.idle), 16'(o_res.idle));
                cmp_field("queued_count", 16'(want.queued_count), 16'(o_res.queued_count));
                cmp_field("awaiting_stop_ack", 16'(want.awaiting_stop_ack),
                          16'(o_res.awaiting_stop_ack));
                n_starts    += want.start_valid;
                n_stops     += want.stop_request;
                n_coalesced += (want.submit_result == SUB_COALESCE);
                n_rejected  += (want.submit_result == SUB_REJECTED);
                n_full      += (want.queued_count == 4'(QDEPTH));
            end
        end
    end

    initial begin
        #3_000_000;
        $display("FAIL");
        $finish;
    end

    initial begin
        logic [15:0] phase_tmo [5];
        int          burst_left;
        int          k;

        phase_tmo[0] = 16'hFFFF;
        phase_tmo[1] = 16'd1;
        phase_tmo[2] = 16'd2;
        phase_tmo[3] = 16'(3 + $urandom_range(0, 5));
        phase_tmo[4] = 16'd4;

        // reset state, empty queue, backend unknown
        add_row(MODE_SUBMIT, 16'h0005, ST_READY, 1,
                res_of(SUB_REJECTED, 0, 16'h0, 0, ST_UNAVAIL, 0, 0, 4'd0, 0));
        // unknown report code folds to other
        add_row(MODE_REPORT, 16'hFFFF, 3'd7, 1,
                res_of(SUB_NONE, 0, 16'h0, 0, ST_OTHER, 0, 0, 4'd0, 0));
        add_row(MODE_REPORT, 16'h0000, ST_READY, 1,
                res_of(SUB_NONE, 0, 16'h0, 0, ST_READY, 1, 1, 4'd0, 0));
        add_row(MODE_TICK, 16'h1234, ST_ERROR, 1,
                res_of(SUB_NONE, 0, 16'h0, 0, ST_READY, 1, 1, 4'd0, 0));
        add_row(MODE_SUBMIT, 16'h0000, ST_READY, 1,
                res_of(SUB_REJECTED, 0, 16'h0, 0, ST_READY, 1, 1, 4'd0, 0));
        add_row(MODE_SUBMIT, 16'hFFFF, ST_READY, 1,
                res_of(SUB_ACCEPTED, 1, 16'hFFFF, 0, ST_BUSY, 1, 0, 4'd0, 0));
        add_row(MODE_SUBMIT, 16'hFFFF, ST_READY, 0, '0);
        add_row(MODE_SUBMIT, 16'h0001, ST_READY, 0, '0);
        add_row(MODE_SUBMIT, 16'h0001, ST_READY, 0, '0);
        for (k = 15; k >= 9; k--)
            add_row(MODE_SUBMIT, 16'(1 << k), ST_READY, 0, '0);
        // queue full: oldest pending id is dropped
        add_row(MODE_SUBMIT, 16'h0100, ST_READY, 0, '0);
        add_row(MODE_STOP, 16'h0000, ST_READY, 1,
                res_of(SUB_NONE, 0, 16'h0, 1, ST_BUSY, 1, 0, 4'd0, 0));
        // zero interval behaves as one tick
        add_cfg_row(16'd0);
        add_row(MODE_REPORT, 16'h0000, ST_READY, 0, '0);
        add_row(MODE_SUBMIT, 16'h00AA, ST_READY, 0, '0);
        add_row(MODE_TICK, 16'h0000, ST_READY, 0, '0);
        add_row(MODE_REPORT, 16'h0000, ST_READY, 0, '0);
        add_row(MODE_SUBMIT, 16'h0055, ST_READY, 0, '0);
        add_row(MODE_TICK, 16'h0000, ST_READY, 0, '0);
        add_row(MODE_TICK, 16'h0000, ST_READY, 1,
                res_of(SUB_NONE, 0, 16'h0, 0, ST_UNAVAIL, 0, 0, 4'd0, 0));
        add_row(MODE_REPORT, 16'h0000, ST_ERROR, 1,
                res_of(SUB_NONE, 0, 16'h0, 0, ST_ERROR, 0, 0, 4'd0, 0));

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_rows[i]) begin
            if (dir_rows[i].cfg_write) begin
                drain_results();
                write_timeout(dir_rows[i].cfg_val);
            end else begin
                issue_req(dir_rows[i].req, dir_rows[i].typed, dir_rows[i].res);
            end
        end

        for (int p = 0; p < 5; p++) begin
            drain_results();
            write_timeout(phase_tmo[p]);
            burst_left = $urandom_range(1, 24);
            for (int n = 0; n < PHASE_REQS; n++) begin
                if (n == PHASE_REQS / 2) begin
                    drain_results();
                    burst_left = $urandom_range(1, 24);
                end else if (burst_left == 0) begin
                    start <= 1'b0;
                    repeat ($urandom_range(1, 6)) @(posedge i_clk);
                    burst_left = $urandom_range(1, 24);
                end
                issue_req(rand_dispatch_req(), 0, '0);
                burst_left--;
            end
        end

        start <= 1'b0;
        for (k = 0; k < 1000 && pending_res.size() != 0; k++)
            @(posedge i_clk);
        repeat (6) @(posedge i_clk);
        if (pending_res.size() != 0)
            $display("%0d ns: %0d results never arrived", $time, pending_res.size());

        $display("Ran %0d requests, %0d results, at timeouts 0, reset value and 1..65535.",
                 n_reqs, n_results);
        $display("Saw %0d starts, %0d stop requests, %0d coalesced, %0d rejected, %0d full queue.",
                 n_starts, n_stops, n_coalesced, n_rejected, n_full);
        if (n_err == 0 && pending_res.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
